>>> hdl/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared widths, codes and types of the linear-fade LED dimmer.
// ----------------------------------------------------------------------------
package lfd_pkg;

    // fixed-point format of the brightness and resolution of the duty map
    localparam int FRACTION_BITS = 16;
    localparam int DUTY_BITS     = 12;

    localparam int LEVEL_W    = 8 + FRACTION_BITS;
    localparam int STEP_W     = LEVEL_W + 1;
    localparam int DUTY_SHIFT = FRACTION_BITS + 8 - DUTY_BITS;

    // field widths
    localparam int MODE_W   = 3;
    localparam int CHANGE_W = 9;
    localparam int SCENE_W  = 2;
    localparam int TTIME_W  = 16;
    localparam int DUTY_W   = 12;
    localparam int TPU_W    = 8;

    // stream words, fields packed from bit 0 and padded to whole bytes
    localparam int IN_FIELDS_W  = 1 + 8 + CHANGE_W + SCENE_W + TTIME_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DUTY_W + 8 + 8 + 1 + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = DUTY_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DUTY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DUTY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TICKS    = 2'd2;

    // serial multiplier and divider widths
    localparam int DEN_W   = TTIME_W + TPU_W;
    localparam int PROD_W  = DUTY_BITS + DUTY_W;
    localparam int DIV_W0  = (LEVEL_W > DEN_W) ? LEVEL_W : DEN_W;
    localparam int DIV_W   = (DIV_W0 > PROD_W) ? DIV_W0 : PROD_W;
    localparam int MUL_B_W = (DUTY_W > TPU_W) ? DUTY_W : TPU_W;
    localparam int CNT_W   = $clog2(DIV_W);

    // command codes
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SWITCH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SCENE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ALERT  = 3'd5;

    // scene codes and their levels
    localparam logic [SCENE_W-1:0] SCENE_RELAX  = 2'd0;
    localparam logic [SCENE_W-1:0] SCENE_BRIGHT = 2'd1;
    localparam logic [SCENE_W-1:0] SCENE_NIGHT  = 2'd2;
    localparam logic [7:0] RELAX_LEVEL  = 8'd144;
    localparam logic [7:0] BRIGHT_LEVEL = 8'd254;
    localparam logic [7:0] NIGHT_LEVEL  = 8'd1;
    localparam logic [7:0] LEVEL_MAX    = 8'd255;
    localparam logic [7:0] LEVEL_MIN    = 8'd1;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = {LEVEL_MAX, {FRACTION_BITS{1'b0}}};
    localparam logic [DIV_W-1:0]   DUTY_FULL = DIV_W'((1 << DUTY_BITS) - 1);

    // configuration reset values
    localparam logic [DUTY_W-1:0] MIN_DUTY_RST = 12'd180;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 12'd2500;
    localparam logic [TPU_W-1:0]  TICKS_RST    = 8'd33;

    // one result word
    typedef struct packed {
        logic              fading;
        logic              light_on;
        logic [7:0]        target_level;
        logic [7:0]        current_level;
        logic [DUTY_W-1:0] pwm_duty;
    } res_t;

endpackage

>>> hdl/led_fade_dimmer_duty_mapper_top.sv
// ----------------------------------------------------------------------------
// led_fade_dimmer_duty_mapper_top
// Linear-fade LED dimmer: commands set the fade, ticks move it, duty mapper.
// ----------------------------------------------------------------------------
// One request in gives one result out. A tick that leaves the brightness where
// it is goes straight to the result stage. A tick that moves it runs the duty
// multiply and divide; a command runs the fade-length multiply and divide
// that give the new step; a command with an immediate jump sets the level and
// then runs the duty multiply and divide. When the new brightness maps to
// duty 0 the duty multiply and divide are skipped. A full result register
// holds the result stage until it empties. All of this runs on one shared
// bit-serial datapath: a shift-add multiplier (fade length times ticks per
// unit, or brightness times duty span) followed by a restoring divider, one
// quotient bit per cycle. A new request is taken once the previous one has
// left the datapath, even while its result still waits in the output
// register. Configuration writes land at once and must be made while the
// block is idle.
module led_fade_dimmer_duty_mapper_top
    import lfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // switch_on, level, level_change, scene, transition_time
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [MODE_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pwm_duty, current_level, target_level, light_on, fading
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DUTY = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic JOB_STEP = 1'b0;
    localparam logic JOB_DUTY = 1'b1;

    // configuration registers
    logic [DUTY_W-1:0] min_duty_reg;
    logic [DUTY_W-1:0] max_duty_reg;
    logic [TPU_W-1:0]  tpu_reg;

    // control and dimmer state
    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    job_reg, job_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    on_reg, on_next;
    logic [7:0]              target_reg, target_next;
    logic [LEVEL_W-1:0]      level_reg, level_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic [DUTY_W-1:0]       duty_reg, duty_next;
    logic                    moved_reg, moved_next;

    // serial datapath
    logic [DIV_W-1:0]   mul_a_reg, mul_a_next;
    logic [MUL_B_W-1:0] mul_b_reg, mul_b_next;
    logic [DIV_W-1:0]   acc_reg, acc_next;
    logic [DIV_W-1:0]   dq_reg, dq_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   divisor_reg, divisor_next;
    logic               neg_reg, neg_next;
    logic               nz_reg, nz_next;
    res_t               out_reg, out_next;

    // request fields
    logic                       in_switch_on;
    logic [7:0]                 in_level;
    logic signed [CHANGE_W-1:0] in_change;
    logic [SCENE_W-1:0]         in_scene;
    logic [TTIME_W-1:0]         in_ttime;

    assign in_switch_on = s_tdata[0];
    assign in_level     = s_tdata[8:1];
    assign in_change    = $signed(s_tdata[17:9]);
    assign in_scene     = s_tdata[19:18];
    assign in_ttime     = s_tdata[35:20];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_duty_reg <= MIN_DUTY_RST;
            max_duty_reg <= MAX_DUTY_RST;
            tpu_reg      <= TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MIN_DUTY: min_duty_reg <= cfg_wdata;
                CFG_MAX_DUTY: max_duty_reg <= cfg_wdata;
                CFG_TICKS:    tpu_reg      <= cfg_wdata[TPU_W-1:0];
                default:      ;
            endcase
        end
    end

    // tick: move one step towards the goal, stop at the target, keep in range
    logic [LEVEL_W-1:0]        tgt_level;
    logic signed [LEVEL_W+2:0] tick_sum, tick_diff, tick_val, tl_ext, top_ext;
    logic                      tick_moved;
    logic [LEVEL_W-1:0]        tick_level;
    logic                      step_pos, step_neg;

    assign tgt_level = {target_reg, {FRACTION_BITS{1'b0}}};
    assign tl_ext    = $signed({3'b000, tgt_level});
    assign top_ext   = $signed({3'b000, LEVEL_TOP});
    assign tick_sum  = $signed({3'b000, level_reg})
                       + $signed({{2{step_reg[STEP_W-1]}}, step_reg});
    assign tick_diff = $signed({3'b000, level_reg})
                       - $signed({{2{step_reg[STEP_W-1]}}, step_reg});
    assign step_neg  = step_reg[STEP_W-1];
    assign step_pos  = !step_reg[STEP_W-1] && (step_reg != '0);

    always_comb
    begin
        tick_moved = 1'b0;
        tick_val   = $signed({3'b000, level_reg});
        if (on_reg)
        begin
            if (level_reg != tgt_level)
            begin
                tick_moved = 1'b1;
                tick_val   = tick_sum;
                if ((step_pos && (tick_sum > tl_ext)) || (step_neg && (tick_sum < tl_ext)))
                begin
                    tick_val = tl_ext;
                end
            end
        end
        else if (level_reg != '0)
        begin
            tick_moved = 1'b1;
            tick_val   = tick_diff;
        end
        if (tick_val < 0)
        begin
            tick_val = '0;
        end
        if (tick_val > top_ext)
        begin
            tick_val = top_ext;
        end
        tick_level = tick_val[LEVEL_W-1:0];
    end

    // command: new switch state, target and level
    logic                 cmd_on;
    logic [7:0]           cmd_target;
    logic [LEVEL_W-1:0]   cmd_level;
    logic signed [10:0]   add_sum;

    assign add_sum = $signed({3'b000, target_reg}) + 11'(in_change);

    always_comb
    begin
        cmd_on     = on_reg;
        cmd_target = target_reg;
        cmd_level  = level_reg;
        case (s_tuser)
            MODE_SWITCH: cmd_on = in_switch_on;
            MODE_SET:    cmd_target = in_level;
            MODE_ADD:
            begin
                if (add_sum > $signed({3'b000, LEVEL_MAX}))
                begin
                    cmd_target = LEVEL_MAX;
                end
                else if (add_sum < $signed({3'b000, LEVEL_MIN}))
                begin
                    cmd_target = LEVEL_MIN;
                end
                else
                begin
                    cmd_target = add_sum[7:0];
                end
            end
            MODE_SCENE:
            begin
                case (in_scene)
                    SCENE_RELAX:  cmd_target = RELAX_LEVEL;
                    SCENE_BRIGHT: cmd_target = BRIGHT_LEVEL;
                    SCENE_NIGHT:  cmd_target = NIGHT_LEVEL;
                    default:      ;
                endcase
            end
            MODE_ALERT:  cmd_level = on_reg ? '0 : LEVEL_TOP;
            default:     ;
        endcase
    end

    // remaining distance to the goal
    logic [LEVEL_W-1:0]       goal_level;
    logic signed [STEP_W-1:0] dist_val, dist_abs;

    assign goal_level = on_reg ? tgt_level : '0;
    assign dist_val   = on_reg ? ($signed({1'b0, goal_level}) - $signed({1'b0, level_reg}))
                               : $signed({1'b0, level_reg});
    assign dist_abs   = dist_val[STEP_W-1] ? -dist_val : dist_val;

    // duty span, brightness index for the duty map
    logic signed [DUTY_W:0] span, span_abs;
    logic [DUTY_BITS-1:0]   duty_v;

    assign span     = $signed({1'b0, max_duty_reg}) - $signed({1'b0, min_duty_reg});
    assign span_abs = span[DUTY_W] ? -span : span;
    assign duty_v   = level_reg[LEVEL_W-1:DUTY_SHIFT];

    // one multiplier bit and one divider bit per cycle
    logic [DIV_W-1:0] acc_add;
    logic [DIV_W:0]   rem_sh;
    logic             div_ge;
    logic [DIV_W-1:0] quot;
    logic [STEP_W-1:0] q_ext;
    logic [DUTY_W-1:0] q_duty;

    assign acc_add = mul_b_reg[0] ? (acc_reg + mul_a_reg) : acc_reg;
    assign rem_sh  = {rem_reg, dq_reg[DIV_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, divisor_reg});
    assign quot    = {dq_reg[DIV_W-2:0], div_ge};
    assign q_ext   = {1'b0, quot[LEVEL_W-1:0]};
    assign q_duty  = quot[DUTY_W-1:0];

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        job_next      = job_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        on_next       = on_reg;
        target_next   = target_reg;
        level_next    = level_reg;
        step_next     = step_reg;
        duty_next     = duty_reg;
        moved_next    = moved_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        acc_next      = acc_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        neg_next      = neg_reg;
        nz_next       = nz_reg;
        out_next      = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    moved_next = 1'b0;
                    if (s_tuser == MODE_TICK)
                    begin
                        level_next = tick_level;
                        moved_next = tick_moved;
                        state_next = tick_moved ? ST_DUTY : ST_FIN;
                    end
                    else if (s_tuser inside {[MODE_SWITCH:MODE_ALERT]})
                    begin
                        on_next     = cmd_on;
                        target_next = cmd_target;
                        level_next  = cmd_level;
                        mul_a_next  = DIV_W'(in_ttime);
                        mul_b_next  = MUL_B_W'(tpu_reg);
                        acc_next    = '0;
                        cnt_next    = '0;
                        job_next    = JOB_STEP;
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_MUL:
            begin
                acc_next   = acc_add;
                mul_a_next = mul_a_reg << 1;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_B_W - 1))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (job_reg == JOB_STEP)
                    begin
                        if (acc_add == '0)
                        begin
                            // zero fade length or zero ticks per unit: jump straight to the goal
                            level_next = goal_level;
                            step_next  = '0;
                            state_next = ST_DUTY;
                        end
                        else
                        begin
                            divisor_next = acc_add;
                            dq_next      = DIV_W'(dist_abs[LEVEL_W-1:0]);
                            neg_next     = dist_val[STEP_W-1];
                            nz_next      = (dist_val != '0);
                            state_next   = ST_DIV;
                        end
                    end
                    else
                    begin
                        divisor_next = DUTY_FULL;
                        dq_next      = acc_add;
                        state_next   = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next = div_ge ? DIV_W'(rem_sh - {1'b0, divisor_reg}) : rem_sh[DIV_W-1:0];
                dq_next  = quot;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                    if (job_reg == JOB_STEP)
                    begin
                        // a fade that is too slow still creeps by one lsb
                        if ((quot == '0) && nz_reg)
                        begin
                            step_next = neg_reg ? '1 : STEP_W'(1);
                        end
                        else
                        begin
                            step_next = neg_reg ? -$signed(q_ext) : $signed(q_ext);
                        end
                    end
                    else
                    begin
                        duty_next = neg_reg ? (min_duty_reg - q_duty) : (min_duty_reg + q_duty);
                    end
                end
            end

            ST_DUTY:
            begin
                if (duty_v == '0)
                begin
                    duty_next  = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    mul_a_next = DIV_W'(duty_v - 1'b1);
                    mul_b_next = MUL_B_W'(span_abs[DUTY_W-1:0]);
                    neg_next   = span[DUTY_W];
                    acc_next   = '0;
                    cnt_next   = '0;
                    job_next   = JOB_DUTY;
                    state_next = ST_MUL;
                end
            end

            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next          = 1'b1;
                    out_next.pwm_duty      = duty_reg;
                    out_next.current_level = level_reg[LEVEL_W-1:FRACTION_BITS];
                    out_next.target_level  = target_reg;
                    out_next.light_on      = on_reg;
                    out_next.fading        = moved_reg;
                    state_next             = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control and dimmer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            job_reg      <= JOB_STEP;
            m_tvalid_reg <= 1'b0;
            on_reg       <= 1'b0;
            target_reg   <= '0;
            level_reg    <= '0;
            step_reg     <= '0;
            duty_reg     <= '0;
            moved_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            job_reg      <= job_next;
            m_tvalid_reg <= m_tvalid_next;
            on_reg       <= on_next;
            target_reg   <= target_next;
            level_reg    <= level_next;
            step_reg     <= step_next;
            duty_reg     <= duty_next;
            moved_reg    <= moved_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        acc_reg     <= acc_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        nz_reg      <= nz_next;
        out_reg     <= out_next;
    end

endmodule

>>> hdl/lfd_checker.sv
// ----------------------------------------------------------------------------
// lfd_checker
// Port-level checks on the dimmer's request and result streams.
// ----------------------------------------------------------------------------
module lfd_checker
    import lfd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic       in_acc, out_acc;
    logic [2:0] pending_reg, pending_next;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // requests taken but whose result has not left yet
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!in_acc && out_acc && (pending_reg != '0))
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the datapath is busy in the cycle after it takes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("request taken on consecutive cycles");

    // no result without a request behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pending_reg != '0))
        else $error("result with no request outstanding");

    // one request in the datapath and one in the output register at most
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("too many requests outstanding");

endmodule

bind led_fade_dimmer_duty_mapper_top lfd_checker u_lfd_checker (.*);

>>> tb/led_fade_dimmer_duty_mapper_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_fade_dimmer_duty_mapper_top_tb
// Self-checking bench for the linear-fade LED dimmer. A directed table covers
// reset state, every command, the unused codes, scenes, level saturation,
// alerts in both light states and immediate jumps. Random command-and-tick
// sequences then run over several duty maps and tick rates, including a
// falling map and a tick rate of zero. Each result is checked against a
// cycle-free bench model of fade engine and duty map, or its row's value.
// ----------------------------------------------------------------------------
module led_fade_dimmer_duty_mapper_top_tb;
    import lfd_pkg::*;

    // codes the package leaves unnamed
    localparam logic [MODE_W-1:0]  MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0]  MODE_SPARE_B = 3'd7;
    localparam logic [SCENE_W-1:0] SCENE_NONE   = 2'd3;

    localparam longint DUTY_DIVISOR   = (1 << DUTY_BITS) - 1;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 60;
    localparam int     REPORT_LIMIT   = 10;
    localparam int     PHASE_ITEMS    = 270;

    // request fields as they sit in s_tdata, switch_on in bit 0
    typedef struct packed {
        logic [TTIME_W-1:0]         fade_time;
        logic [SCENE_W-1:0]         scene;
        logic signed [CHANGE_W-1:0] change;
        logic [7:0]                 level;
        logic                       switch_on;
    } cmd_fields_t;

    typedef struct {
        logic [MODE_W-1:0] op;
        cmd_fields_t       f;
        bit                typed;
        res_t              res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // model state of the dimmer
    bit                lamp_on;
    logic [7:0]        goal_level;
    longint            bright_fx;
    longint            fade_step;
    logic [DUTY_W-1:0] duty_reg;
    int                cfg_min;
    int                cfg_max;
    int                cfg_ticks;

    res_t     due_outputs[$];
    dir_row_t directed_rows[$];
    res_t     predicted;
    res_t     observed;
    res_t     wanted;
    bit       row_typed;
    res_t     row_res;
    int       fault_count;
    int       results_seen;
    int       idle_cycles;
    int       burst_left;

    led_fade_dimmer_duty_mapper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // brightness to duty, falling when max is below min
    function automatic void map_duty();
        longint v;
        longint d;
        v = bright_fx >>> DUTY_SHIFT;
        if (v == 0)
        begin
            duty_reg = '0;
        end
        else
        begin
            d = (v - 1) * (longint'(cfg_max) - longint'(cfg_min)) / DUTY_DIVISOR
                + longint'(cfg_min);
            duty_reg = DUTY_W'(d);
        end
    endfunction

    // one request through the fade engine, giving its result
    function automatic res_t step_dimmer(input logic [MODE_W-1:0] op, input cmd_fields_t f);
        longint top_fx;
        longint tgt_fx;
        longint den;
        longint dist_fx;
        longint q;
        int     sum;
        bit     moved;
        res_t   r;
        top_fx = longint'(LEVEL_MAX) << FRACTION_BITS;
        moved  = 1'b0;
        if (op == MODE_TICK)
        begin
            tgt_fx = longint'(goal_level) << FRACTION_BITS;
            if (lamp_on)
            begin
                if (bright_fx != tgt_fx)
                begin
                    moved = 1'b1;
                    bright_fx += fade_step;
                    // stop at the target on overshoot
                    if ((fade_step > 0 && bright_fx > tgt_fx) ||
                        (fade_step < 0 && bright_fx < tgt_fx))
                        bright_fx = tgt_fx;
                end
            end
            else if (bright_fx != 0)
            begin
                moved = 1'b1;
                bright_fx -= fade_step;
                if (bright_fx < 0)
                    bright_fx = 0;
            end
            if (bright_fx < 0)
                bright_fx = 0;
            if (bright_fx > top_fx)
                bright_fx = top_fx;
            if (moved)
                map_duty();
        end
        else if (op <= MODE_ALERT)
        begin
            case (op)
                MODE_SWITCH: lamp_on = f.switch_on;
                MODE_SET:    goal_level = f.level;
                MODE_ADD:
                begin
                    sum = int'(goal_level) + int'($signed(f.change));
                    if (sum > int'(LEVEL_MAX))
                        sum = int'(LEVEL_MAX);
                    if (sum < int'(LEVEL_MIN))
                        sum = int'(LEVEL_MIN);
                    goal_level = 8'(sum);
                end
                MODE_SCENE:
                begin
                    if (f.scene == SCENE_RELAX)
                        goal_level = RELAX_LEVEL;
                    else if (f.scene == SCENE_BRIGHT)
                        goal_level = BRIGHT_LEVEL;
                    else if (f.scene == SCENE_NIGHT)
                        goal_level = NIGHT_LEVEL;
                end
                default: bright_fx = lamp_on ? 0 : top_fx;
            endcase
            // new step toward the goal, or an immediate jump
            den     = longint'(f.fade_time) * longint'(cfg_ticks);
            tgt_fx  = lamp_on ? (longint'(goal_level) << FRACTION_BITS) : 0;
            dist_fx = lamp_on ? tgt_fx - bright_fx : bright_fx;
            if (den == 0)
            begin
                bright_fx = tgt_fx;
                fade_step = 0;
                map_duty();
            end
            else
            begin
                q = dist_fx / den;
                if (q == 0 && dist_fx > 0)
                    q = 1;
                if (q == 0 && dist_fx < 0)
                    q = -1;
                fade_step = q;
            end
        end
        r.pwm_duty      = duty_reg;
        r.current_level = 8'(bright_fx >>> FRACTION_BITS);
        r.target_level  = goal_level;
        r.light_on      = lamp_on;
        r.fading        = moved;
        return r;
    endfunction

    function automatic dir_row_t make_row(input logic [MODE_W-1:0] op, input bit sw,
                                          input int lvl, input int chg,
                                          input logic [SCENE_W-1:0] scn, input int fade,
                                          input bit typed = 1'b0, input res_t res = '0);
        dir_row_t row;
        row.op          = op;
        row.f.switch_on = sw;
        row.f.level     = 8'(lvl);
        row.f.change    = CHANGE_W'(chg);
        row.f.scene     = scn;
        row.f.fade_time = TTIME_W'(fade);
        row.typed       = typed;
        row.res         = res;
        return row;
    endfunction

    // mostly short fades, some long, now and then any value
    function automatic logic [TTIME_W-1:0] pick_fade_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return '0;
        if (roll < 75)
            return TTIME_W'($urandom_range(1, 3));
        if (roll < 93)
            return TTIME_W'($urandom_range(4, 200));
        return TTIME_W'($urandom);
    endfunction

    function automatic cmd_fields_t random_fields();
        return cmd_fields_t'(IN_FIELDS_W'({$urandom, $urandom}));
    endfunction

    // sender: bursts of requests with random gaps between them
    task automatic send_request(input logic [MODE_W-1:0] op, input cmd_fields_t f,
                                input bit typed = 1'b0, input res_t res = '0);
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid  = 1'b1;
        s_tuser   = op;
        s_tdata   = IN_DATA_W'(f);
        row_typed = typed;
        row_res   = res;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold off until every outstanding result is back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (due_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            CFG_MIN_DUTY: cfg_min = int'(val & 32'hFFF);
            CFG_MAX_DUTY: cfg_max = int'(val & 32'hFFF);
            CFG_TICKS:    cfg_ticks = int'(val & 32'hFF);
            default: ;
        endcase
    endtask

    // one command then a run of ticks, with some stray requests mixed in
    task automatic play_random_fades(input int count);
        int          sent;
        int          roll;
        cmd_fields_t f;
        logic [MODE_W-1:0] op;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(0, 99);
            f = random_fields();
            f.fade_time = pick_fade_time();
            if (roll < 8)
            begin
                op = MODE_W'($urandom_range(0, 7));
            end
            else
            begin
                op = MODE_W'($urandom_range(MODE_SWITCH, MODE_ALERT));
                f.switch_on = ($urandom_range(0, 9) < 7);
            end
            send_request(op, f);
            sent++;
            repeat ($urandom_range(0, 40))
            begin
                send_request(MODE_TICK, random_fields());
                sent++;
            end
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    // receiver stalls on a rotating pattern, with fully ready stretches
    initial
    begin
        int unsigned stall_pat;
        int          phase_left;
        int          bit_pos;
        bit          steady;
        m_tready   = 1'b0;
        phase_left = 0;
        bit_pos    = 0;
        stall_pat  = '1;
        steady     = 1'b1;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(16, 240);
                steady     = ($urandom_range(0, 3) == 0);
                stall_pat  = $urandom | 32'h1;
            end
            phase_left--;
            m_tready = steady || stall_pat[bit_pos];
            bit_pos  = (bit_pos + 1) % 32;
        end
    end

    // accepted requests feed the model, accepted results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = step_dimmer(s_tuser, cmd_fields_t'(s_tdata[IN_FIELDS_W-1:0]));
                due_outputs.push_back(row_typed ? row_res : predicted);
            end
            if (m_tvalid && m_tready)
            begin
                observed = res_t'(m_tdata[OUT_FIELDS_W-1:0]);
                results_seen++;
                if (due_outputs.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing outstanding", results_seen);
                end
                else
                begin
                    wanted = due_outputs.pop_front();
                    if (observed !== wanted)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                        begin
                            $write("result %0d exp/got: duty %0d/%0d level %0d/%0d",
                                   results_seen, wanted.pwm_duty, observed.pwm_duty,
                                   wanted.current_level, observed.current_level);
                            $display(" target %0d/%0d on %0b/%0b moving %0b/%0b",
                                     wanted.target_level, observed.target_level,
                                     wanted.light_on, observed.light_on,
                                     wanted.fading, observed.fading);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog on cycles with no transfer on either side
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL led_fade_dimmer_duty_mapper_top");
        $finish;
    end

    initial
    begin
        res_t on_only;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_TICK;
        cfg_we       = 1'b0;
        cfg_addr     = CFG_MIN_DUTY;
        cfg_wdata    = '0;
        row_typed    = 1'b0;
        row_res      = '0;
        fault_count  = 0;
        results_seen = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        lamp_on      = 1'b0;
        goal_level   = '0;
        bright_fx    = 0;
        fade_step    = 0;
        duty_reg     = '0;
        cfg_min      = int'(MIN_DUTY_RST);
        cfg_max      = int'(MAX_DUTY_RST);
        cfg_ticks    = int'(TICKS_RST);
        on_only          = '0;
        on_only.light_on = 1'b1;

        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed requests under the reset configuration
        directed_rows.push_back(make_row(MODE_TICK, 0, 0, 0, SCENE_RELAX, 0, 1'b1, '0));
        directed_rows.push_back(make_row(MODE_SPARE_A, 1, 255, 255, SCENE_NONE, 65535,
                                         1'b1, '0));
        directed_rows.push_back(make_row(MODE_SPARE_B, 0, 0, 0, SCENE_RELAX, 0, 1'b1, '0));
        directed_rows.push_back(make_row(MODE_SWITCH, 1, 0, 0, SCENE_RELAX, 0, 1'b1, on_only));
        directed_rows.push_back(make_row(MODE_SET, 0, 255, 0, SCENE_RELAX, 0));
        directed_rows.push_back(make_row(MODE_TICK, 0, 0, 0, SCENE_RELAX, 0));
        // saturation of the target at both ends
        directed_rows.push_back(make_row(MODE_ADD, 0, 0, -255, SCENE_RELAX, 0));
        directed_rows.push_back(make_row(MODE_ADD, 0, 0, 255, SCENE_RELAX, 1));
        directed_rows.push_back(make_row(MODE_TICK, 0, 0, 0, SCENE_RELAX, 0));
        directed_rows.push_back(make_row(MODE_TICK, 0, 0, 0, SCENE_RELAX, 0));
        // all scene codes
        directed_rows.push_back(make_row(MODE_SCENE, 0, 0, 0, SCENE_RELAX, 0));
        directed_rows.push_back(make_row(MODE_SCENE, 0, 0, 0, SCENE_BRIGHT, 2));
        directed_rows.push_back(make_row(MODE_SCENE, 0, 0, 0, SCENE_NIGHT, 0));
        directed_rows.push_back(make_row(MODE_SCENE, 0, 0, 0, SCENE_NONE, 0));
        // longest fade gives the one-lsb step
        directed_rows.push_back(make_row(MODE_SET, 0, 0, 0, SCENE_RELAX, 65535));
        directed_rows.push_back(make_row(MODE_TICK, 0, 0, 0, SCENE_RELAX, 0));
        // alert while on drops to dark and fades back
        directed_rows.push_back(make_row(MODE_SET, 0, 200, 0, SCENE_RELAX, 0));
        directed_rows.push_back(make_row(MODE_ALERT, 0, 0, 0, SCENE_RELAX, 1));
        directed_rows.push_back(make_row(MODE_TICK, 0, 0, 0, SCENE_RELAX, 0));
        directed_rows.push_back(make_row(MODE_SWITCH, 0, 0, 0, SCENE_RELAX, 3));
        directed_rows.push_back(make_row(MODE_TICK, 0, 0, 0, SCENE_RELAX, 0));
        // alert while off, as a jump and as a fade down
        directed_rows.push_back(make_row(MODE_ALERT, 0, 0, 0, SCENE_RELAX, 0));
        directed_rows.push_back(make_row(MODE_ALERT, 0, 0, 0, SCENE_RELAX, 1));
        directed_rows.push_back(make_row(MODE_TICK, 1, 255, -1, SCENE_NONE, 65535));
        directed_rows.push_back(make_row(MODE_SWITCH, 1, 0, 0, SCENE_RELAX, 0));

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].f,
                         directed_rows[i].typed, directed_rows[i].res);

        // random phases over several maps and tick rates
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_results();
            repeat (SETTLE_CYCLES) @(negedge clk);
            case (ph)
                0:
                begin
                    write_reg(CFG_MIN_DUTY, 0);
                    write_reg(CFG_MAX_DUTY, 4095);
                    write_reg(CFG_TICKS, 1);
                end
                1:
                begin
                    write_reg(CFG_MIN_DUTY, 4095);
                    write_reg(CFG_MAX_DUTY, 0);
                    write_reg(CFG_TICKS, 255);
                end
                2:
                begin
                    write_reg(CFG_MIN_DUTY, $urandom_range(0, 4095));
                    write_reg(CFG_MAX_DUTY, $urandom_range(0, 4095));
                    write_reg(CFG_TICKS, 0);
                end
                3:
                begin
                    write_reg(CFG_MIN_DUTY, $urandom_range(0, 4095));
                    write_reg(CFG_MAX_DUTY, $urandom_range(0, 4095));
                    write_reg(CFG_TICKS, $urandom_range(1, 255));
                end
                default:
                begin
                    write_reg(CFG_MIN_DUTY, MIN_DUTY_RST);
                    write_reg(CFG_MAX_DUTY, MAX_DUTY_RST);
                    write_reg(CFG_TICKS, TICKS_RST);
                end
            endcase
            play_random_fades(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && due_outputs.size() == 0)
            $display("PASS led_fade_dimmer_duty_mapper_top");
        else
            $display("FAIL led_fade_dimmer_duty_mapper_top");
        $finish;
    end

endmodule

>>> led_fade_dimmer_duty_mapper_top.f
hdl/lfd_pkg.sv
hdl/led_fade_dimmer_duty_mapper_top.sv
hdl/lfd_checker.sv
tb/led_fade_dimmer_duty_mapper_top_tb.sv
